>>> sv/fwas_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FIFO with adjacent swap.
package fwas_pkg;

    localparam int VAL_W = 5;   // stored entry and value fields
    localparam int CMD_W = 2;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_SWAP = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture input word
        logic exec;      // check and run push / pop, start reads
        logic wr_a;      // swap, first write
        logic wr_b;      // swap, second write
        logic rd_head;   // read head entry, capture read result
        logic load;      // load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic op_ok;
    } t_dp_stat;

endpackage

>>> sv/fwas_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module fwas_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> sv/fwas_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the FIFO with adjacent swap: handshakes and step order.
module fwas_ctrl
    import fwas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SWAP1 = 6'b000100,
        S_SWAP2 = 6'b001000,
        S_HEAD  = 6'b010000,
        S_LOAD  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid & ~i_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.op_ok && i_stat.cmd == CMD_SWAP) begin
                    n_state = S_SWAP1;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_SWAP1: begin
                o_cmd.wr_a = 1'b1;
                n_state    = S_SWAP2;
            end
            S_SWAP2: begin
                o_cmd.wr_b = 1'b1;
                n_state    = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                // wait for room in the output register
                if (!r_out_valid || i_ready) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_out_valid || i_ready))
        else $error("output register overwritten");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_EXEC))
        else $error("accepted word not executed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("output word dropped before accept");

endmodule

>>> sv/fwas_dp.sv
`timescale 1ns / 1ps
// Datapath: head pointer, count, entry RAM, checks and output register.
module fwas_dp
    import fwas_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic [CMD_W-1:0] i_in_cmd,
    input  logic [POS_W-1:0] i_position,
    output logic [ST_W-1:0]  o_status,
    output logic [VAL_W-1:0] o_length,
    output logic [VAL_W-1:0] o_head_value,
    output logic [VAL_W-1:0] o_read_value
);

    localparam int IW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [IW:0]   DEPTH_I = (IW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // ring index of base + off, both below the depth
    function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                           input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_I) begin
            sum = sum - DEPTH_I;
        end
        return sum[IW-1:0];
    endfunction

    t_cmd             r_cmd;
    logic [POS_W-1:0] r_pos;
    t_status          r_status;
    logic [IW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [VAL_W-1:0] r_swap;
    logic [VAL_W-1:0] r_read_value;

    logic [CMPW-1:0]  pos_c, pos_m1, cnt_c;
    logic [IW-1:0]    slot_a, slot_b, slot_tail;
    logic             op_ok;
    t_status          fail_code;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr, ram_raddr_a;
    logic [VAL_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

    assign pos_c     = CMPW'(r_pos);
    assign pos_m1    = pos_c - CMPW'(1);
    assign cnt_c     = CMPW'(r_count);
    assign slot_a    = ring(r_head, pos_m1[IW-1:0]);
    assign slot_b    = ring(r_head, pos_c[IW-1:0]);
    assign slot_tail = ring(r_head, r_count[IW-1:0]);

    always_comb begin
        op_ok     = 1'b0;
        fail_code = ST_BADPOS;
        case (r_cmd)
            CMD_PUSH: begin
                op_ok     = (r_count != DEPTH_C);
                fail_code = ST_FULL;
            end
            CMD_POP: begin
                op_ok     = (r_count != '0);
                fail_code = ST_EMPTY;
            end
            CMD_SWAP: op_ok = (r_pos != '0) && (pos_c < cnt_c);
            default:  op_ok = (r_pos != '0) && (pos_c <= cnt_c);
        endcase
    end

    assign o_stat.cmd   = r_cmd;
    assign o_stat.op_ok = op_ok;

    // RAM ports: one write, port A for head / position, port B for the neighbor
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_tail;
        ram_wdata = VAL_W'(r_count + CW'(1));
        if (i_cmd.exec && r_cmd == CMD_PUSH && op_ok) begin
            ram_we = 1'b1;
        end else if (i_cmd.wr_a) begin
            ram_we    = 1'b1;
            ram_waddr = slot_a;
            ram_wdata = ram_rdata_b;
        end else if (i_cmd.wr_b) begin
            ram_we    = 1'b1;
            ram_waddr = slot_b;
            ram_wdata = r_swap;
        end
    end

    // position read only while executing; head otherwise, so a stalled load
    // keeps seeing the head entry
    assign ram_raddr_a = i_cmd.exec ? slot_a : r_head;

    fwas_ram #(
        .WIDTH (VAL_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (slot_b),
        .o_rdata_b (ram_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec && op_ok) begin
            if (r_cmd == CMD_PUSH) begin
                r_count <= r_count + CW'(1);
            end else if (r_cmd == CMD_POP) begin
                r_head  <= ring(r_head, IW'(1));
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= t_cmd'(i_in_cmd);
            r_pos <= i_position;
        end
        if (i_cmd.exec) begin
            r_status <= op_ok ? ST_OK : fail_code;
        end
        if (i_cmd.wr_a) begin
            r_swap <= ram_rdata_a;
        end
        if (i_cmd.rd_head) begin
            r_read_value <= (r_cmd == CMD_READ && r_status == ST_OK) ? ram_rdata_a : '0;
        end
        if (i_cmd.load) begin
            o_status     <= r_status;
            o_length     <= VAL_W'(r_count);
            o_head_value <= (r_count != '0) ? ram_rdata_a : '0;
            o_read_value <= r_read_value;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("count above depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_cmd == CMD_PUSH && op_ok) |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_cmd == CMD_POP && op_ok) |=> r_count == $past(r_count) - CW'(1))
        else $error("pop did not shrink queue");

endmodule

>>> sv/fifo_with_adjacent_swap.sv
`timescale 1ns / 1ps
// Top level of the bounded ring FIFO with adjacent-entry swap.
//
// A queue of QUEUE_DEPTH entries held in a two-read, one-write RAM, with a
// head pointer and an entry count in flops. Each input word carries a command
// (push, pop, swap position with next, read position) and a 1-based position;
// each command returns exactly one output word with status, length after the
// command, head entry (zero when empty) and, for a good read, the entry read.
// A push stores the new queue length. Push when full, pop when empty and a
// bad position return an error status and leave the queue as it was.
// Rate: one word is taken at a time. Push, pop and read step through accept,
// check/execute, head read and output load before the next accept; a swap
// adds two RAM writes after check/execute, since they share the single write
// port. The output word sits in its own register, so the next input word is
// taken while it waits; the sequencer holds only if a new result is ready
// before the previous one was taken. The RAM needs no clearing after reset.
module fifo_with_adjacent_swap
    import fwas_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [POS_W-1:0] i_position,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ST_W-1:0]  o_status,
    output logic [VAL_W-1:0] o_length,
    output logic [VAL_W-1:0] o_head_value,
    output logic [VAL_W-1:0] o_read_value
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: input and output handshakes, step order
    fwas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // queue state, entry RAM and output word
    fwas_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_in_cmd     (i_cmd),
        .i_position   (i_position),
        .o_status     (o_status),
        .o_length     (o_length),
        .o_head_value (o_head_value),
        .o_read_value (o_read_value)
    );

endmodule
